[sv/steering_rudder_positioner_top_defines.svh]
// assertion macros for the steering rudder positioner
// used by the top level; expects clk_i and rst_ni in scope
`ifndef STEERING_RUDDER_POSITIONER_TOP_DEFINES_SVH
`define STEERING_RUDDER_POSITIONER_TOP_DEFINES_SVH

// clocked check, off while reset is asserted
`define SRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define SRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/srp_pkg.sv]
// shared types and constants of the steering rudder positioner
// no dependencies; used by the step logic and the top level
package srp_pkg;

  // position codes, as recorded and as commanded
  localparam logic [1:0] POS_STRAIGHT = 2'd0;
  localparam logic [1:0] POS_LEFT     = 2'd1;
  localparam logic [1:0] POS_RIGHT    = 2'd2;

  // decoded feedback wires {brown, green}
  localparam logic [1:0] SENSE_STRAIGHT = 2'd0;
  localparam logic [1:0] SENSE_END      = 2'd3;

  // motor direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // input word kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // register indexes on the config port
  localparam logic [1:0] REG_RETURN_SPEED  = 2'd0;
  localparam logic [1:0] REG_TURN_SPEED    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;
  localparam logic [1:0] REG_OVERRUN_TICKS = 2'd3;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register reset values
  localparam logic [7:0]  RETURN_SPEED_RST  = 8'd100;
  localparam logic [7:0]  TURN_SPEED_RST    = 8'd255;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd2000;
  localparam logic [7:0]  OVERRUN_TICKS_RST = 8'd20;

  localparam int unsigned ELAPSED_W = 17;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RETURN,
    PH_FAST,
    PH_OVERRUN
  } phase_e;

  typedef struct packed {
    logic [7:0]  return_speed;
    logic [7:0]  turn_speed;
    logic [15:0] timeout_ticks;
    logic [7:0]  overrun_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           recorded_position;
    phase_e               move_phase;
    logic [1:0]           goal_position;
    logic [ELAPSED_W-1:0] phase_elapsed;
    logic [7:0]           overrun_count;
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] target;
    logic       brown_wire;
    logic       green_wire;
  } item_t;

  typedef struct packed {
    logic [1:0] motor_direction;
    logic [7:0] motor_speed;
    logic [1:0] rudder_position;
    logic [1:0] sensed_position;
    logic       busy_res;
    logic       done_res;
    logic       timeout_error;
  } result_t;

endpackage

[sv/srp_if.sv]
// valid/ready channels of the steering rudder positioner: input and result words
// depends on nothing; the field widths match the srp_pkg types
interface srp_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] target;
  logic       brown_wire;
  logic       green_wire;

  modport source (output valid, operation, target, brown_wire, green_wire, input ready);
  modport sink (input valid, operation, target, brown_wire, green_wire, output ready);
endinterface

interface srp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_direction;
  logic [7:0] motor_speed;
  logic [1:0] rudder_position;
  logic [1:0] sensed_position;
  logic       busy_res;
  logic       done_res;
  logic       timeout_error;

  modport source (
    output valid, motor_direction, motor_speed, rudder_position, sensed_position,
           busy_res, done_res, timeout_error,
    input  ready
  );
  modport sink (
    input  valid, motor_direction, motor_speed, rudder_position, sensed_position,
           busy_res, done_res, timeout_error,
    output ready
  );
endinterface

[sv/srp_step.sv]
// next-state and result logic for one word of the rudder positioner
// depends on srp_pkg; purely combinational, state is held by the top level
module srp_step (
  input  srp_pkg::cfg_t   cfg_i,
  input  srp_pkg::state_t state_i,
  input  srp_pkg::item_t  item_i,
  output srp_pkg::state_t state_o,
  output srp_pkg::result_t result_o
);

  logic [1:0]                    sensed;
  logic [srp_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic                          timed_out;
  logic [7:0]                    overrun_inc;
  logic                          done;
  logic                          err;
  srp_pkg::state_t               nxt;

  // wire decode and the shared counters
  assign sensed      = {item_i.brown_wire, item_i.green_wire};
  assign elapsed_inc = (&state_i.phase_elapsed) ? state_i.phase_elapsed
                                                 : state_i.phase_elapsed + 1'b1;
  assign timed_out   = elapsed_inc > {1'b0, cfg_i.timeout_ticks};
  assign overrun_inc = state_i.overrun_count + 8'd1;

  // phase sequencing
  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    err  = 1'b0;
    if (item_i.operation == srp_pkg::OP_CMD) begin
      // target code 3 is not a position and is dropped
      if (state_i.move_phase == srp_pkg::PH_IDLE && item_i.target <= srp_pkg::POS_RIGHT) begin
        if (item_i.target == state_i.recorded_position) begin
          done = 1'b1;
        end else begin
          nxt.goal_position = item_i.target;
          nxt.phase_elapsed = '0;
          nxt.overrun_count = '0;
          nxt.move_phase    = (state_i.recorded_position == srp_pkg::POS_STRAIGHT)
                              ? srp_pkg::PH_FAST : srp_pkg::PH_RETURN;
        end
      end
    end else begin
      unique case (state_i.move_phase)
        srp_pkg::PH_RETURN: begin
          if (sensed == srp_pkg::SENSE_STRAIGHT) begin
            nxt.recorded_position = srp_pkg::POS_STRAIGHT;
            if (state_i.goal_position == srp_pkg::POS_STRAIGHT) begin
              nxt.move_phase = srp_pkg::PH_IDLE;
              done           = 1'b1;
            end else begin
              nxt.move_phase    = srp_pkg::PH_FAST;
              nxt.phase_elapsed = '0;
            end
          end else begin
            nxt.phase_elapsed = elapsed_inc;
            if (timed_out) begin
              nxt.move_phase = srp_pkg::PH_IDLE;
              err            = 1'b1;
            end
          end
        end
        srp_pkg::PH_FAST: begin
          if (sensed == srp_pkg::SENSE_END) begin
            nxt.overrun_count = '0;
            if (cfg_i.overrun_ticks == 8'd0) begin
              nxt.move_phase        = srp_pkg::PH_IDLE;
              nxt.recorded_position = state_i.goal_position;
              done                  = 1'b1;
            end else begin
              nxt.move_phase = srp_pkg::PH_OVERRUN;
            end
          end else begin
            nxt.phase_elapsed = elapsed_inc;
            if (timed_out) begin
              nxt.move_phase = srp_pkg::PH_IDLE;
              err            = 1'b1;
            end
          end
        end
        srp_pkg::PH_OVERRUN: begin
          nxt.overrun_count = overrun_inc;
          if (overrun_inc >= cfg_i.overrun_ticks) begin
            nxt.move_phase        = srp_pkg::PH_IDLE;
            nxt.recorded_position = state_i.goal_position;
            done                  = 1'b1;
          end
        end
        default: begin
          // idle tick: only the wires are decoded
        end
      endcase
    end
  end

  // motor drive from the state after this word
  always_comb begin
    result_o = '0;
    unique case (nxt.move_phase)
      srp_pkg::PH_RETURN: begin
        result_o.motor_direction = (nxt.recorded_position == srp_pkg::POS_LEFT)
                                   ? srp_pkg::DIR_CCW : srp_pkg::DIR_CW;
        result_o.motor_speed     = cfg_i.return_speed;
      end
      srp_pkg::PH_FAST, srp_pkg::PH_OVERRUN: begin
        result_o.motor_direction = (nxt.goal_position == srp_pkg::POS_LEFT)
                                   ? srp_pkg::DIR_CW : srp_pkg::DIR_CCW;
        result_o.motor_speed     = cfg_i.turn_speed;
      end
      default: begin
        result_o.motor_direction = srp_pkg::DIR_STOP;
        result_o.motor_speed     = 8'd0;
      end
    endcase
    result_o.rudder_position = nxt.recorded_position;
    result_o.sensed_position = sensed;
    result_o.busy_res        = (nxt.move_phase != srp_pkg::PH_IDLE);
    result_o.done_res        = done;
    result_o.timeout_error   = err;
  end

  assign state_o = nxt;

endmodule

[sv/steering_rudder_positioner_top.sv]
// Steering rudder positioner. Takes one word per clock cycle while the result
// register is free: a 1 ms tick with the two feedback wire levels, or a move
// command. Each word yields one result word (input register, then result
// register), and the next word can enter in the very next cycle; the input stage
// moves whenever the result register is empty or being read in that cycle.
// Registers on the APB port: 0x0 slow speed, 0x4 fast speed, 0x8 timeout
// ticks, 0xC overrun ticks; write them only while no word is in flight.
// Depends on srp_pkg, srp_if.sv, srp_step and the defines header.
`include "steering_rudder_positioner_top_defines.svh"

module steering_rudder_positioner_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  srp_item_if.sink                       item_i,
  srp_result_if.source                   result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srp_pkg::PADDR_W-1:0]    paddr,
  input  logic [srp_pkg::PDATA_W-1:0]    pwdata,
  output logic [srp_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  srp_pkg::cfg_t    cfg_q;
  srp_pkg::state_t  state_q, state_d;
  srp_pkg::item_t   item_q;
  srp_pkg::result_t result_q, result_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             out_load;
  logic             in_move;
  logic             cfg_write;
  logic [1:0]       reg_idx;
  logic             res_both_pulses;
  logic             res_idle;
  logic             res_motor_off;
  logic             state_idle;

  // config port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.return_speed  <= srp_pkg::RETURN_SPEED_RST;
      cfg_q.turn_speed    <= srp_pkg::TURN_SPEED_RST;
      cfg_q.timeout_ticks <= srp_pkg::TIMEOUT_TICKS_RST;
      cfg_q.overrun_ticks <= srp_pkg::OVERRUN_TICKS_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        srp_pkg::REG_RETURN_SPEED:  cfg_q.return_speed  <= pwdata[7:0];
        srp_pkg::REG_TURN_SPEED:    cfg_q.turn_speed    <= pwdata[7:0];
        srp_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[15:0];
        srp_pkg::REG_OVERRUN_TICKS: cfg_q.overrun_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      srp_pkg::REG_RETURN_SPEED:  prdata = {24'd0, cfg_q.return_speed};
      srp_pkg::REG_TURN_SPEED:    prdata = {24'd0, cfg_q.turn_speed};
      srp_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_q.timeout_ticks};
      srp_pkg::REG_OVERRUN_TICKS: prdata = {24'd0, cfg_q.overrun_ticks};
      default:                    prdata = '0;
    endcase
  end

  // pipeline flow: the result register loads when empty or being drained
  assign out_load     = !out_valid_q || result_o.ready;
  assign in_move      = in_valid_q && out_load;
  assign item_i.ready = !in_valid_q || out_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.operation  <= item_i.operation;
      item_q.target     <= item_i.target;
      item_q.brown_wire <= item_i.brown_wire;
      item_q.green_wire <= item_i.green_wire;
    end
  end

  // one step of the positioner per word
  srp_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // positioner state, updated as a word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.recorded_position <= srp_pkg::POS_STRAIGHT;
      state_q.move_phase        <= srp_pkg::PH_IDLE;
      state_q.goal_position     <= srp_pkg::POS_STRAIGHT;
      state_q.phase_elapsed     <= '0;
      state_q.overrun_count     <= '0;
    end else if (in_move) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.motor_direction = result_q.motor_direction;
  assign result_o.motor_speed     = result_q.motor_speed;
  assign result_o.rudder_position = result_q.rudder_position;
  assign result_o.sensed_position = result_q.sensed_position;
  assign result_o.busy_res        = result_q.busy_res;
  assign result_o.done_res        = result_q.done_res;
  assign result_o.timeout_error   = result_q.timeout_error;

  // terms used by the checks
  assign res_both_pulses = result_q.done_res && result_q.timeout_error;
  assign res_idle        = out_valid_q && !result_q.busy_res;
  assign res_motor_off   = (result_q.motor_direction == srp_pkg::DIR_STOP)
                           && (result_q.motor_speed == 8'd0);
  assign state_idle      = (state_q.move_phase == srp_pkg::PH_IDLE);

  // checks
  `SRP_ASSERT(a_done_err_excl, out_valid_q |-> !res_both_pulses, "done and timeout in one word")
  `SRP_ASSERT(a_idle_stopped, res_idle |-> res_motor_off, "motor driven while idle")
  `SRP_ASSERT(a_step_lands, in_move |=> out_valid_q, "stepped word lost before result register")
  `SRP_ASSERT_ALWAYS(a_phase_idle_reset, !rst_ni |-> state_idle, "phase not idle in reset")

endmodule
